// ===== rtl/core/uart_idle_timeout_frame_receiver_macros.svh =====
// Assertion helpers shared by the frame receiver RTL.
`ifndef UART_IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH
`define UART_IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define UITFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define UITFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/uitfr_pkg.sv =====
`default_nettype none

package uitfr_pkg;

    // Field widths fixed by the interface
    localparam int ACTION_W = 3;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int TICK_W   = 8;

    // Store depth default and register reset values
    localparam int FRAME_DEPTH_DEFAULT        = 64;
    localparam logic [TICK_W-1:0] GAP_RESET     = 8'd5;
    localparam logic [TICK_W-1:0] HOLDOFF_RESET = 8'd5;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GAP_TIMEOUT   = 1'b0,
        CFG_ERROR_HOLDOFF = 1'b1
    } t_cfg_index;

    // Input item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_RX_BYTE = 3'd0,
        ACT_OVERRUN = 3'd1,
        ACT_TICK    = 3'd2,
        ACT_SCAN    = 3'd3,
        ACT_READ    = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_TX_BUSY   = 2'd2,
        ST_DROPPED   = 2'd3
    } t_status;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_BUSY     = 2'd1,
        PH_COMPLETE = 2'd2,
        PH_READY    = 2'd3
    } t_phase;

    // Read-out sequencer
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PRIME,
        SEQ_STREAM
    } t_seq;

    // Frame RAM port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/uitfr_frame_ram.sv =====
`default_nettype none

module uitfr_frame_ram
    import uitfr_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(FRAME_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire t_ram_ctrl         i_ctrl,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [FRAME_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Store a received byte
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/uart_idle_timeout_frame_receiver.sv =====
// Receive framer that collects bytes into a frame and closes the frame after a quiet gap of
// gap_timeout_ticks millisecond ticks; a scan event promotes a complete frame to ready (or,
// after an overrun, drops it and loads the error hold-off), and a read streams the ready
// frame out as one result per byte with last on the final byte. Received-byte, overrun,
// tick and scan items, and refused reads, each give one result. A read is accepted, then
// the frame RAM's registered read port is primed, then the bytes stream out one per cycle
// through that single read port while the output does not stall. No new item is taken
// during a read-out. The frame RAM needs no clearing after reset.
`default_nettype none

`include "uart_idle_timeout_frame_receiver_macros.svh"

module uart_idle_timeout_frame_receiver
    import uitfr_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write channel
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [0:0]          i_cfg_index,
    input  wire logic [TICK_W-1:0]   i_cfg_data,
    // input item channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [DATA_W-1:0]   i_rx_data,
    input  wire logic                i_tx_busy,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [DATA_W-1:0]        o_data_byte,
    output logic [LEN_W-1:0]         o_frame_length,
    output logic [1:0]               o_receiver_state,
    output logic                     o_last
);

    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FRAME_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // configuration registers
    logic [TICK_W-1:0] r_gap_cfg;
    logic [TICK_W-1:0] r_holdoff_cfg;

    // receiver state
    t_phase            r_phase,     n_phase;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [TICK_W-1:0] r_gap,       n_gap;
    logic              r_ovr,       n_ovr;
    logic [CNT_W-1:0]  r_ready_len, n_ready_len;

    // read-out sequencer
    t_seq              r_seq,       n_seq;
    logic [CNT_W-1:0]  r_idx,       n_idx;
    logic [CNT_W-1:0]  r_len,       n_len;

    // output register
    logic              r_out_valid, n_out_valid;
    t_status           r_status,    n_status;
    logic [DATA_W-1:0] r_data,      n_data;
    logic [LEN_W-1:0]  r_len_out,   n_len_out;
    t_phase            r_state_out, n_state_out;
    logic              r_last,      n_last;

    // frame RAM access
    t_ram_ctrl         ram_ctrl;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    logic              in_fire;
    logic              out_free;
    logic              start_stream;
    logic              stream_last;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  idx_inc;

    assign o_cfg_ready  = 1'b1;
    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_seq == SEQ_IDLE) && out_free;
    assign in_fire      = i_in_valid && o_in_ready;
    assign eff_count    = (r_phase == PH_IDLE) ? '0 : r_count;
    assign idx_inc      = r_idx + ONE_C;
    assign stream_last  = (idx_inc == r_len);
    assign start_stream = in_fire && (t_action'(i_action) == ACT_READ) && !i_tx_busy
                          && (r_phase == PH_READY) && (r_ready_len != '0);

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (start_stream) begin
                    n_seq = SEQ_PRIME;
                end
            end
            SEQ_PRIME: begin
                n_seq = SEQ_STREAM;
            end
            SEQ_STREAM: begin
                if (out_free && stream_last) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    // Item processing, read-out and output register loading
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_gap       = r_gap;
        n_ovr       = r_ovr;
        n_ready_len = r_ready_len;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_len_out   = r_len_out;
        n_state_out = r_state_out;
        n_last      = r_last;
        ram_ctrl    = '0;
        ram_rd_addr = r_idx[ADDR_W-1:0];

        if (in_fire) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_data      = '0;
            n_len_out   = '0;
            n_last      = 1'b1;
            case (t_action'(i_action))
                ACT_RX_BYTE: begin
                    if (r_phase == PH_IDLE || r_phase == PH_BUSY) begin
                        n_phase = PH_BUSY;
                        n_count = eff_count;
                        if (eff_count < DEPTH_C) begin
                            ram_ctrl.wr_en = 1'b1;
                            n_count        = eff_count + ONE_C;
                            n_gap          = r_gap_cfg;
                        end else begin
                            n_status = ST_DROPPED;
                        end
                    end else begin
                        n_status = ST_DROPPED;
                    end
                end
                ACT_OVERRUN: begin
                    n_ovr = 1'b1;
                end
                ACT_TICK: begin
                    if (r_gap != '0) begin
                        n_gap = r_gap - TICK_W'(1);
                        if (r_gap == TICK_W'(1) && r_phase == PH_BUSY) begin
                            n_phase = PH_COMPLETE;
                        end
                    end
                end
                ACT_SCAN: begin
                    // clear a latched overrun first, then promote a complete frame
                    if (r_ovr) begin
                        n_phase = PH_IDLE;
                        n_gap   = r_holdoff_cfg;
                        n_count = '0;
                        n_ovr   = 1'b0;
                    end
                    if (n_phase == PH_COMPLETE) begin
                        n_ready_len = r_count;
                        n_phase     = PH_READY;
                    end
                end
                ACT_READ: begin
                    if (i_tx_busy) begin
                        n_status = ST_TX_BUSY;
                    end else if (r_phase == PH_READY) begin
                        n_phase     = PH_IDLE;
                        n_ready_len = '0;
                        if (start_stream) begin
                            // no result yet: the bytes follow from the sequencer
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_len       = r_ready_len;
                            n_idx       = '0;
                        end
                    end else begin
                        n_status = ST_NOT_READY;
                    end
                end
                default: begin
                end
            endcase
            n_state_out = n_phase;
        end else if (r_seq == SEQ_PRIME) begin
            // fetch the first byte
            ram_ctrl.rd_en = 1'b1;
            ram_rd_addr    = r_idx[ADDR_W-1:0];
        end else if (r_seq == SEQ_STREAM && out_free) begin
            // hand over the fetched byte and fetch the next one
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_data      = ram_rd_data;
            n_len_out   = LEN_W'(r_len);
            n_state_out = r_phase;
            n_last      = stream_last;
            if (!stream_last) begin
                n_idx          = idx_inc;
                ram_ctrl.rd_en = 1'b1;
                ram_rd_addr    = idx_inc[ADDR_W-1:0];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_cfg     <= GAP_RESET;
            r_holdoff_cfg <= HOLDOFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GAP_TIMEOUT:   r_gap_cfg     <= i_cfg_data;
                CFG_ERROR_HOLDOFF: r_holdoff_cfg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_gap       <= '0;
            r_ovr       <= 1'b0;
            r_ready_len <= '0;
            r_seq       <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_gap       <= n_gap;
            r_ovr       <= n_ovr;
            r_ready_len <= n_ready_len;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_status    <= n_status;
        r_data      <= n_data;
        r_len_out   <= n_len_out;
        r_state_out <= n_state_out;
        r_last      <= n_last;
    end

    uitfr_frame_ram #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_ctrl    (ram_ctrl),
        .i_wr_addr (eff_count[ADDR_W-1:0]),
        .i_wr_data (i_rx_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_data_byte      = r_data;
    assign o_frame_length   = r_len_out;
    assign o_receiver_state = r_state_out;
    assign o_last           = r_last;

    `UITFR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "byte count beyond depth")
    `UITFR_ASSERT_NOW(a_ready_len, r_phase == PH_READY, r_ready_len != '0, "empty ready frame")
    `UITFR_ASSERT_NEXT(a_prime_once, r_seq == SEQ_PRIME, r_seq == SEQ_STREAM, "prime stuck")
    `UITFR_ASSERT_NOW(a_idx_bound, r_seq == SEQ_STREAM, r_idx < r_len, "index past length")
    `UITFR_ASSERT_NOW(a_readout_idle, r_seq != SEQ_IDLE, r_phase == PH_IDLE, "phase moved")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
    import uitfr_pkg::*;

    localparam int STORE_DEPTH    = FRAME_DEPTH_DEFAULT;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int MAX_PAUSE      = 14;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLD_STRETCH   = 300;
    localparam int RESET_CYCLES   = 11;
    localparam int DIRECTED_COUNT = 25;

    // Action codes the block ignores
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   data_byte;
        logic [LEN_W-1:0]    frame_length;
        t_phase              state;
        logic                last;
    } frame_result_t;

    // One row of the directed script; fixed rows carry their expected result
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [DATA_W-1:0]   rx;
        logic                txb;
        logic                fixed;
        t_status             status;
        t_phase              state;
    } script_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [0:0]          i_cfg_index;
    logic [TICK_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACTION_W-1:0] i_action;
    logic [DATA_W-1:0]   i_rx_data;
    logic                i_tx_busy;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_data_byte;
    logic [LEN_W-1:0]    o_frame_length;
    logic [1:0]          o_receiver_state;
    logic                o_last;

    uart_idle_timeout_frame_receiver #(
        .FRAME_DEPTH(STORE_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_rx_data       (i_rx_data),
        .i_tx_busy       (i_tx_busy),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_data_byte     (o_data_byte),
        .o_frame_length  (o_frame_length),
        .o_receiver_state(o_receiver_state),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Framer copy: configuration and receiver state
    logic [TICK_W-1:0] cfg_gap;
    logic [TICK_W-1:0] cfg_holdoff;
    t_phase            pr_phase;
    int unsigned       pr_count;
    logic [TICK_W-1:0] pr_gap;
    logic              pr_overrun;
    int unsigned       pr_ready_len;
    logic [DATA_W-1:0] pr_store [STORE_DEPTH];

    frame_result_t frame_expect_q [$];
    frame_result_t result_log_q [$];
    int unsigned   fault_count;
    int unsigned   items_sent;
    int unsigned   send_pause_max;
    int unsigned   sink_pause_max;
    int unsigned   hold_request;
    script_row_t   directed_rows [DIRECTED_COUNT];

    function automatic int unsigned draw_pause(input int unsigned mx);
        return (mx == 0) ? 0 : $urandom_range(0, mx);
    endfunction

    function automatic logic [DATA_W-1:0] rnd_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [ACTION_W-1:0] rnd_action();
        return ACTION_W'($urandom_range(0, 7));
    endfunction

    // Work out the results one accepted item causes and advance the framer copy
    task automatic predict_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] rx,
                                input logic txb);
        t_status     st;
        int unsigned n;
        logic        streamed;
        st = ST_OK;
        streamed = 1'b0;
        case (act)
            ACT_RX_BYTE: begin
                if (pr_phase == PH_IDLE || pr_phase == PH_BUSY) begin
                    if (pr_phase == PH_IDLE) begin
                        pr_phase = PH_BUSY;
                        pr_count = 0;
                    end
                    if (pr_count < STORE_DEPTH) begin
                        pr_store[pr_count[STORE_AW-1:0]] = rx;
                        pr_count++;
                        pr_gap = cfg_gap;
                    end else begin
                        st = ST_DROPPED;
                    end
                end else begin
                    st = ST_DROPPED;
                end
            end
            ACT_OVERRUN: pr_overrun = 1'b1;
            ACT_TICK: begin
                if (pr_gap != 0) begin
                    pr_gap = pr_gap - 8'd1;
                    if (pr_gap == 0 && pr_phase == PH_BUSY)
                        pr_phase = PH_COMPLETE;
                end
            end
            ACT_SCAN: begin
                // a latched overrun wins over a complete frame
                if (pr_overrun) begin
                    pr_phase = PH_IDLE;
                    pr_gap = cfg_holdoff;
                    pr_count = 0;
                    pr_overrun = 1'b0;
                end
                if (pr_phase == PH_COMPLETE) begin
                    pr_ready_len = pr_count;
                    pr_phase = PH_READY;
                end
            end
            ACT_READ: begin
                if (txb) begin
                    st = ST_TX_BUSY;
                end else if (pr_phase == PH_READY) begin
                    n = pr_ready_len;
                    pr_ready_len = 0;
                    pr_phase = PH_IDLE;
                    streamed = 1'b1;
                    if (n == 0)
                        frame_expect_q.push_back('{ST_OK, 8'h00, 7'd0, PH_IDLE, 1'b1});
                    for (int i = 0; i < n; i++)
                        frame_expect_q.push_back('{ST_OK, pr_store[i[STORE_AW-1:0]],
                                                   LEN_W'(n), PH_IDLE, (i == n - 1)});
                end else begin
                    st = ST_NOT_READY;
                end
            end
            default: ;
        endcase
        if (!streamed)
            frame_expect_q.push_back('{st, 8'h00, 7'd0, pr_phase, 1'b1});
    endtask

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] rx,
                             input logic txb);
        int unsigned pause;
        pause = draw_pause(send_pause_max);
        if (pause != 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_rx_data  <= rx;
        i_tx_busy  <= txb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        predict_item(act, rx, txb);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (frame_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [TICK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GAP_TIMEOUT)
            cfg_gap = value;
        else
            cfg_holdoff = value;
        @(posedge i_clk);
    endtask

    // Mostly whole frames with random content, some overrun drops, some noise
    task automatic random_traffic(input int unsigned budget);
        int unsigned goal;
        int unsigned pick;
        int unsigned nbytes;
        goal = items_sent + budget;
        while (items_sent < goal) begin
            send_pause_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_PAUSE;
            sink_pause_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_PAUSE;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                nbytes = ($urandom_range(0, 11) == 0) ?
                         $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 3) : $urandom_range(1, 8);
                repeat (nbytes) begin
                    send_item(ACT_RX_BYTE, rnd_byte(), rnd_bit());
                    if (nbytes <= 8 && $urandom_range(0, 4) == 0)
                        send_item(ACT_TICK, rnd_byte(), rnd_bit());
                end
                // run out the gap, or drop the frame where the gap is long
                if (cfg_gap <= 16) begin
                    while (pr_phase == PH_BUSY && pr_gap != 0)
                        send_item(ACT_TICK, rnd_byte(), rnd_bit());
                end else begin
                    send_item(ACT_OVERRUN, rnd_byte(), rnd_bit());
                end
                if ($urandom_range(0, 3) == 0)
                    send_item(ACT_RX_BYTE, rnd_byte(), rnd_bit());
                if ($urandom_range(0, 5) == 0)
                    send_item(ACT_READ, rnd_byte(), 1'b0);
                send_item(ACT_SCAN, rnd_byte(), rnd_bit());
                if ($urandom_range(0, 3) == 0)
                    send_item(ACT_READ, rnd_byte(), 1'b1);
                send_item(ACT_READ, rnd_byte(), 1'b0);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4))
                    send_item(ACT_RX_BYTE, rnd_byte(), rnd_bit());
                send_item(ACT_OVERRUN, rnd_byte(), rnd_bit());
                if ($urandom_range(0, 1) == 0)
                    send_item(ACT_TICK, rnd_byte(), rnd_bit());
                send_item(ACT_SCAN, rnd_byte(), rnd_bit());
                if ($urandom_range(0, 1) == 0)
                    send_item(ACT_READ, rnd_byte(), 1'b0);
                repeat ($urandom_range(0, 3))
                    send_item(ACT_TICK, rnd_byte(), rnd_bit());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(rnd_action(), rnd_byte(), rnd_bit());
            end
        end
    endtask

    task automatic check_result(input frame_result_t got);
        frame_result_t want;
        if (frame_expect_q.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
                $display("[%0t] result with nothing expected:", $time,
                         " st %0d data %02h len %0d ph %0d last %0d",
                         got.status, got.data_byte, got.frame_length, got.state, got.last);
            fault_count++;
        end else begin
            want = frame_expect_q.pop_front();
            if (got.status !== want.status || got.data_byte !== want.data_byte ||
                got.frame_length !== want.frame_length || got.state !== want.state ||
                got.last !== want.last) begin
                if (fault_count < REPORT_LIMIT)
                    $display("[%0t] mismatch:", $time,
                             " exp st %0d data %02h len %0d ph %0d last %0d,",
                             want.status, want.data_byte, want.frame_length, want.state,
                             want.last,
                             " got st %0d data %02h len %0d ph %0d last %0d",
                             got.status, got.data_byte, got.frame_length, got.state,
                             got.last);
                fault_count++;
            end
        end
    endtask

    // Capture each taken result at the rising edge, compare it on the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            result_log_q.push_back('{t_status'(o_status), o_data_byte, o_frame_length,
                                     t_phase'(o_receiver_state), o_last});
    end

    always @(negedge i_clk) begin
        if (result_log_q.size() != 0)
            check_result(result_log_q.pop_front());
    end

    // Result side: random stalls per item, plus a long hold-off on request
    initial begin : result_sink
        int unsigned pause;
        int unsigned hold_cycles;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                hold_cycles = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
            end
            pause = draw_pause(sink_pause_max);
            if (pause != 0) begin
                i_out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : run_limit
        #20000000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        // after reset: refusals, ignored codes, idle tick and scan, one frame end to end, then an overrun drop
        directed_rows = '{
            '{ACT_READ,      8'h00, 1'b1, 1'b1, ST_TX_BUSY,   PH_IDLE},
            '{ACT_READ,      8'hFF, 1'b0, 1'b1, ST_NOT_READY, PH_IDLE},
            '{ACT_SPARE_LO,  8'h00, 1'b0, 1'b1, ST_OK,        PH_IDLE},
            '{ACT_SPARE_HI,  8'hFF, 1'b1, 1'b1, ST_OK,        PH_IDLE},
            '{ACT_SPARE_MID, 8'h5A, 1'b1, 1'b1, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b0, 1'b1, ST_OK,        PH_IDLE},
            '{ACT_SCAN,      8'h00, 1'b0, 1'b1, ST_OK,        PH_IDLE},
            '{ACT_RX_BYTE,   8'h00, 1'b0, 1'b1, ST_OK,        PH_BUSY},
            '{ACT_RX_BYTE,   8'hFF, 1'b0, 1'b1, ST_OK,        PH_BUSY},
            '{ACT_RX_BYTE,   8'hA5, 1'b1, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b1, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'hFF, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_RX_BYTE,   8'h3C, 1'b0, 1'b1, ST_DROPPED,   PH_COMPLETE},
            '{ACT_READ,      8'h00, 1'b0, 1'b1, ST_NOT_READY, PH_COMPLETE},
            '{ACT_SCAN,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_RX_BYTE,   8'hC3, 1'b0, 1'b1, ST_DROPPED,   PH_READY},
            '{ACT_READ,      8'h00, 1'b1, 1'b1, ST_TX_BUSY,   PH_READY},
            '{ACT_READ,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_RX_BYTE,   8'h5A, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_OVERRUN,   8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_SCAN,      8'h00, 1'b1, 1'b0, ST_OK,        PH_IDLE},
            '{ACT_TICK,      8'h00, 1'b0, 1'b0, ST_OK,        PH_IDLE}
        };
        fault_count    = 0;
        items_sent     = 0;
        hold_request   = 0;
        send_pause_max = MAX_PAUSE;
        sink_pause_max = MAX_PAUSE;
        cfg_gap        = GAP_RESET;
        cfg_holdoff    = HOLDOFF_RESET;
        pr_phase       = PH_IDLE;
        pr_count       = 0;
        pr_gap         = '0;
        pr_overrun     = 1'b0;
        pr_ready_len   = 0;

        // hold reset with every input at a known value
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GAP_TIMEOUT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_RX_BYTE;
        i_rx_data   <= '0;
        i_tx_busy   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed script; fixed rows replace the predicted result
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            send_item(directed_rows[r].act, directed_rows[r].rx, directed_rows[r].txb);
            if (directed_rows[r].fixed) begin
                frame_expect_q.delete(frame_expect_q.size() - 1);
                frame_expect_q.push_back('{directed_rows[r].status, 8'h00, 7'd0,
                                           directed_rows[r].state, 1'b1});
            end
        end

        // shortest gap, no hold-off
        release_input();
        wait_drained();
        cfg_write(CFG_GAP_TIMEOUT, 8'd1);
        cfg_write(CFG_ERROR_HOLDOFF, 8'd0);
        random_traffic(70);

        // long result stall while items keep coming
        release_input();
        wait_drained();
        cfg_write(CFG_GAP_TIMEOUT, 8'd3);
        cfg_write(CFG_ERROR_HOLDOFF, 8'd255);
        random_traffic(15);
        hold_request = HOLD_STRETCH;
        random_traffic(55);

        // longest gap: one frame closed by silence, then some traffic
        release_input();
        wait_drained();
        cfg_write(CFG_GAP_TIMEOUT, 8'd255);
        cfg_write(CFG_ERROR_HOLDOFF, 8'd7);
        send_pause_max = 0;
        sink_pause_max = 0;
        repeat (3) send_item(ACT_RX_BYTE, rnd_byte(), rnd_bit());
        while (pr_phase == PH_BUSY && pr_gap != 0)
            send_item(ACT_TICK, rnd_byte(), rnd_bit());
        send_item(ACT_SCAN, rnd_byte(), 1'b0);
        send_item(ACT_READ, rnd_byte(), 1'b0);
        random_traffic(15);

        // pause the sender until everything is out, then carry on
        release_input();
        wait_drained();
        cfg_write(CFG_GAP_TIMEOUT, 8'd2);
        cfg_write(CFG_ERROR_HOLDOFF, 8'd1);
        random_traffic(35);
        release_input();
        wait_drained();
        random_traffic(35);

        release_input();
        wait_drained();
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
